// ===== sv/volume_threshold_trim_bounds_unit_assert.svh =====
// Assertion macros shared by the trim-bounds RTL.
`ifndef VOLUME_THRESHOLD_TRIM_BOUNDS_UNIT_ASSERT_SVH
`define VOLUME_THRESHOLD_TRIM_BOUNDS_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define VTTB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define VTTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/vttb_pkg.sv =====
// Shared types and constants of the volume threshold trim-bounds unit.
`default_nettype none
package vttb_pkg;

  localparam int SAMPLE_W     = 32;
  localparam int SIZE_W       = 11;
  localparam int MARGIN_W     = 4;
  localparam int TRIM_W       = 9;
  localparam int KEPT_W       = 11;
  localparam int TRIM_MAX     = 511;
  localparam int MAX_SIZE_DEF = 1024;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // result packing, lowest bit up
  localparam int OUT_DATA_W = 64;
  localparam int ANY_BIT    = 3 * TRIM_W + 3 * KEPT_W;

  // register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_SIZE_X    = 3'd1,
    CFG_SIZE_Y    = 3'd2,
    CFG_SIZE_Z    = 3'd3,
    CFG_MARGIN    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] threshold;
    logic [SIZE_W-1:0]   size_x;
    logic [SIZE_W-1:0]   size_y;
    logic [SIZE_W-1:0]   size_z;
    logic [MARGIN_W-1:0] margin;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    threshold: '0,
    size_x:    SIZE_W'(1),
    size_y:    SIZE_W'(1),
    size_z:    SIZE_W'(1),
    margin:    MARGIN_W'(2)
  };

  // width of an effective size for a given size limit
  function automatic int size_w_for(int max_size);
    return (max_size > 2047) ? SIZE_W : $clog2(max_size + 1);
  endfunction

  // width of a raster position for a given size limit
  function automatic int pos_w_for(int max_size);
    return ($clog2(max_size) > SIZE_W) ? SIZE_W : $clog2(max_size);
  endfunction

endpackage
`default_nettype wire

// ===== sv/vttb_scan.sv =====
// Raster position counters, hit bounds tracking and end-of-volume snapshot.
`default_nettype none
`include "volume_threshold_trim_bounds_unit_assert.svh"
module vttb_scan
  import vttb_pkg::*;
#(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic signed [SAMPLE_W-1:0]            in_sample,
  input  logic signed [SAMPLE_W-1:0]            threshold,
  input  logic [2:0][size_w_for(MAX_SIZE)-1:0]  eff_size,
  output logic                                  snap_valid,
  input  logic                                  snap_ready,
  output logic [2:0][pos_w_for(MAX_SIZE)-1:0]   snap_low,
  output logic [2:0][pos_w_for(MAX_SIZE)-1:0]   snap_high,
  output logic                                  snap_hit
);

  localparam int SZ_W  = size_w_for(MAX_SIZE);
  localparam int POS_W = pos_w_for(MAX_SIZE);

  logic [2:0][POS_W-1:0] pos_r, pos_nxt;
  logic [2:0][POS_W-1:0] low_r, low_nxt;
  logic [2:0][POS_W-1:0] high_r, high_nxt;
  logic                  hit_seen_r, hit_seen_nxt;
  logic [2:0][POS_W-1:0] snap_low_r, snap_low_nxt;
  logic [2:0][POS_W-1:0] snap_high_r, snap_high_nxt;
  logic                  snap_hit_r, snap_hit_nxt;
  logic                  snap_v_r, snap_v_nxt;

  logic                  in_acc;
  logic                  hit;
  logic [2:0]            wrap;
  logic                  last;
  logic [2:0][POS_W-1:0] low_upd, high_upd;

  // a request may enter unless a finished snapshot is stuck
  assign in_tready = !snap_v_r || snap_ready;
  assign in_acc    = in_tvalid && in_tready;
  assign hit       = in_sample > threshold;

  // axis wrap: next position would reach the effective size
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      wrap[a] = ((SZ_W + 1)'(pos_r[a]) + (SZ_W + 1)'(1)) >= (SZ_W + 1)'(eff_size[a]);
    end
    last = wrap[0] && wrap[1] && wrap[2];
  end

  // bounds including the current voxel
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      low_upd[a]  = low_r[a];
      high_upd[a] = high_r[a];
      if (hit) begin
        if (!hit_seen_r || pos_r[a] < low_r[a])  low_upd[a]  = pos_r[a];
        if (!hit_seen_r || pos_r[a] > high_r[a]) high_upd[a] = pos_r[a];
      end
    end
  end

  // scan state and snapshot update
  always_comb begin
    pos_nxt       = pos_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    hit_seen_nxt  = hit_seen_r;
    snap_low_nxt  = snap_low_r;
    snap_high_nxt = snap_high_r;
    snap_hit_nxt  = snap_hit_r;
    snap_v_nxt    = snap_v_r && !snap_ready;
    if (in_acc) begin
      pos_nxt[0] = wrap[0] ? '0 : POS_W'(pos_r[0] + 1'b1);
      if (wrap[0]) pos_nxt[1] = wrap[1] ? '0 : POS_W'(pos_r[1] + 1'b1);
      if (wrap[0] && wrap[1]) pos_nxt[2] = wrap[2] ? '0 : POS_W'(pos_r[2] + 1'b1);
      if (last) begin
        snap_low_nxt  = low_upd;
        snap_high_nxt = high_upd;
        snap_hit_nxt  = hit_seen_r || hit;
        snap_v_nxt    = 1'b1;
        low_nxt       = '1;
        high_nxt      = '0;
        hit_seen_nxt  = 1'b0;
      end else begin
        low_nxt      = low_upd;
        high_nxt     = high_upd;
        hit_seen_nxt = hit_seen_r || hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      low_r      <= '1;
      high_r     <= '0;
      hit_seen_r <= 1'b0;
      snap_v_r   <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      low_r      <= low_nxt;
      high_r     <= high_nxt;
      hit_seen_r <= hit_seen_nxt;
      snap_v_r   <= snap_v_nxt;
    end
  end

  // snapshot payload
  always_ff @(posedge clk) begin
    snap_low_r  <= snap_low_nxt;
    snap_high_r <= snap_high_nxt;
    snap_hit_r  <= snap_hit_nxt;
  end

  assign snap_valid = snap_v_r;
  assign snap_low   = snap_low_r;
  assign snap_high  = snap_high_r;
  assign snap_hit   = snap_hit_r;

  `VTTB_ASSERT_SAME(a_bounds_ordered, hit_seen_r,
    low_r[0] <= high_r[0] && low_r[1] <= high_r[1] && low_r[2] <= high_r[2],
    "hit bounds out of order")
  `VTTB_ASSERT_NEXT(a_last_restarts, in_acc && last,
    snap_v_r && !hit_seen_r && pos_r == '0,
    "end of volume did not restart scan")
  `VTTB_ASSERT_SAME(a_snap_ordered, snap_v_r && snap_hit_r,
    snap_low_r[0] <= snap_high_r[0] && snap_low_r[1] <= snap_high_r[1] &&
    snap_low_r[2] <= snap_high_r[2],
    "snapshot bounds out of order")

endmodule
`default_nettype wire

// ===== sv/vttb_trim.sv =====
// Per-axis trim and kept size from the snapshot, with the result register.
`default_nettype none
`include "volume_threshold_trim_bounds_unit_assert.svh"
module vttb_trim
  import vttb_pkg::*;
#(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  snap_valid,
  output logic                                  snap_ready,
  input  logic [2:0][pos_w_for(MAX_SIZE)-1:0]   snap_low,
  input  logic [2:0][pos_w_for(MAX_SIZE)-1:0]   snap_high,
  input  logic                                  snap_hit,
  input  logic [2:0][size_w_for(MAX_SIZE)-1:0]  eff_size,
  input  logic [MARGIN_W-1:0]                   margin,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [OUT_DATA_W-1:0]                 out_tdata
);

  localparam int SZ_W  = size_w_for(MAX_SIZE);
  localparam int CW    = SZ_W + 5;

  logic [CW-1:0]             m_w;
  logic [2:0][CW-1:0]        first_w, last_w, top_w, lo_w, hi_sum_w, hi_w, th_w, t_w;
  logic [2:0][CW-1:0]        eff_w, dbl_w, kept_w;
  logic [2:0][TRIM_W-1:0]    trim;
  logic [2:0][KEPT_W-1:0]    kept;
  logic [OUT_DATA_W-1:0]     data_nxt;
  logic [OUT_DATA_W-1:0]     out_data_r;
  logic                      out_v_r, out_v_nxt;

  assign m_w = CW'(margin);

  // trim arithmetic, one lane per axis
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      first_w[a]  = CW'(snap_low[a]);
      last_w[a]   = CW'(snap_high[a]);
      eff_w[a]    = CW'(eff_size[a]);
      top_w[a]    = eff_w[a] - CW'(1);
      lo_w[a]     = (first_w[a] > m_w) ? first_w[a] - m_w : '0;
      hi_sum_w[a] = last_w[a] + m_w;
      hi_w[a]     = (hi_sum_w[a] > top_w[a]) ? top_w[a] : hi_sum_w[a];
      th_w[a]     = top_w[a] - hi_w[a];
      t_w[a]      = (lo_w[a] < th_w[a]) ? lo_w[a] : th_w[a];
      if (!snap_hit)                 trim[a] = '0;
      else if (int'(t_w[a]) > TRIM_MAX) trim[a] = TRIM_W'(TRIM_MAX);
      else                           trim[a] = TRIM_W'(t_w[a]);
      dbl_w[a]    = CW'({trim[a], 1'b0});
      kept_w[a]   = (eff_w[a] > dbl_w[a]) ? eff_w[a] - dbl_w[a] : '0;
      kept[a]     = KEPT_W'(kept_w[a]);
    end
  end

  assign data_nxt = OUT_DATA_W'({snap_hit, kept[2], kept[1], kept[0],
                                 trim[2], trim[1], trim[0]});

  // result register
  assign snap_ready = !out_v_r || out_tready;

  always_comb begin
    out_v_nxt = out_v_r && !out_tready;
    if (snap_valid && snap_ready) out_v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) out_data_r <= data_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  `VTTB_ASSERT_SAME(a_no_hit_no_trim, out_v_r && !out_data_r[ANY_BIT],
    out_data_r[3*TRIM_W-1:0] == '0,
    "trim without any hit")
  `VTTB_ASSERT_NEXT(a_snap_lands, snap_valid && snap_ready, out_v_r,
    "snapshot taken but no result held")
  `VTTB_ASSERT_SAME(a_kept_nonzero, out_v_r,
    out_data_r[3*TRIM_W +: KEPT_W] != '0 &&
    out_data_r[3*TRIM_W+KEPT_W +: KEPT_W] != '0 &&
    out_data_r[3*TRIM_W+2*KEPT_W +: KEPT_W] != '0,
    "kept size of zero")

endmodule
`default_nettype wire

// ===== sv/volume_threshold_trim_bounds_unit.sv =====
// Volume threshold trim-bounds unit: top level with register file and size limits.
//
// Voxels of one volume arrive in raster order (x fastest, then y, then z) at one
// request per clock while input ready is high; each voxel costs one compare
// against the threshold and a min/max update of the hit bounds held in the scan
// stage. After the voxel that completes the volume (counted from the configured
// sizes, 0 read as 1 and values above MAX_SIZE read as MAX_SIZE) a snapshot of
// the bounds is registered and the trim stage registers the result from it.
// Input ready drops only while a snapshot and a finished result both wait on the
// output side. No clearing pass is needed after reset. The user writes registers
// through the cfg port only while no volume is in flight; nothing enforces it.
`default_nettype none
module volume_threshold_trim_bounds_unit
  import vttb_pkg::*;
#(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // register write port
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // voxel stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [SAMPLE_W-1:0]    in_tdata,   // [31:0] sample
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata   // trim_x, trim_y, trim_z, kept_x,
                                             // kept_y, kept_z, any_above, pad
);

  localparam int SZ_W  = (MAX_SIZE > 2047) ? SIZE_W : $clog2(MAX_SIZE + 1);
  localparam int POS_W = ($clog2(MAX_SIZE) > SIZE_W) ? SIZE_W : $clog2(MAX_SIZE);

  cfg_t                  cfg_r, cfg_nxt;
  logic [2:0][SIZE_W-1:0] raw_size;
  logic [2:0][SZ_W-1:0]  eff_size;
  logic                  snap_valid, snap_ready, snap_hit;
  logic [2:0][POS_W-1:0] snap_low, snap_high;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_THRESHOLD: cfg_nxt.threshold = cfg_wdata[SAMPLE_W-1:0];
        CFG_SIZE_X:    cfg_nxt.size_x    = cfg_wdata[SIZE_W-1:0];
        CFG_SIZE_Y:    cfg_nxt.size_y    = cfg_wdata[SIZE_W-1:0];
        CFG_SIZE_Z:    cfg_nxt.size_z    = cfg_wdata[SIZE_W-1:0];
        CFG_MARGIN:    cfg_nxt.margin    = cfg_wdata[MARGIN_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // effective sizes: zero reads as one, clamp at MAX_SIZE
  assign raw_size = {cfg_r.size_z, cfg_r.size_y, cfg_r.size_x};

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (raw_size[a] == '0)               eff_size[a] = SZ_W'(1);
      else if (int'(raw_size[a]) > MAX_SIZE) eff_size[a] = SZ_W'(MAX_SIZE);
      else                                 eff_size[a] = SZ_W'(raw_size[a]);
    end
  end

  vttb_scan #(
    .MAX_SIZE (MAX_SIZE)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_sample  ($signed(in_tdata)),
    .threshold  ($signed(cfg_r.threshold)),
    .eff_size   (eff_size),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap_low   (snap_low),
    .snap_high  (snap_high),
    .snap_hit   (snap_hit)
  );

  vttb_trim #(
    .MAX_SIZE (MAX_SIZE)
  ) u_trim (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap_low   (snap_low),
    .snap_high  (snap_high),
    .snap_hit   (snap_hit),
    .eff_size   (eff_size),
    .margin     (cfg_r.margin),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire
